FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the converter RTL.
// Both sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication that is checked within the same clock edge.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cdoc_pkg.sv
`timescale 1ns / 1ps

package cdoc_pkg;

  // Conversion direction.
  localparam logic ACT_DATE_TO_ORD = 1'b0;
  localparam logic ACT_ORD_TO_DATE = 1'b1;

  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_DEC  = 4'd12;
  localparam logic [8:0] DAYS_COMMON = 9'd365;
  localparam logic [8:0] DAYS_LEAP   = 9'd366;

  // floor(y / 25) = (y * DIV25_RECIP) >> DIV25_SHIFT, exact for every 14-bit y.
  localparam int unsigned DIV25_SHIFT = 19;
  localparam logic [14:0] DIV25_RECIP = 15'd20972;
  localparam logic [13:0] DIV25_CONST = 14'd25;

  typedef struct packed {
    logic       action;
    logic [13:0] year;
    logic [3:0] month;
    logic [6:0] day;
    logic [8:0] ordinal;
  } item_t;

  // After the first stage: the item plus floor(year / 25).
  typedef struct packed {
    item_t      item;
    logic [9:0] quo25;
  } s1_t;

  // After the second stage: checks done, month and days-before settled.
  typedef struct packed {
    logic       action;
    logic       ok;
    logic       leap;
    logic [3:0] month;
    logic [8:0] base;
    logic [6:0] day;
    logic [8:0] ordinal;
  } s2_t;

  typedef struct packed {
    logic       valid_result;
    logic       leap_year;
    logic [8:0] ordinal_out;
    logic [3:0] month_out;
    logic [4:0] day_out;
  } result_t;

  // Days before the first of the month in a common year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] b;
    case (m)
      4'd2:    b = 9'd31;
      4'd3:    b = 9'd59;
      4'd4:    b = 9'd90;
      4'd5:    b = 9'd120;
      4'd6:    b = 9'd151;
      4'd7:    b = 9'd181;
      4'd8:    b = 9'd212;
      4'd9:    b = 9'd243;
      4'd10:   b = 9'd273;
      4'd11:   b = 9'd304;
      4'd12:   b = 9'd334;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  // Month length in a common year; zero for codes that name no month.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] l;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   l = 5'd30;
      4'd2:                                      l = 5'd28;
      default:                                   l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

FILE: hw/rtl/calendar_date_ordinal_converter_core.sv
// A word taken at the input passes through the stage-one, stage-two and output registers.
// Throughput: one word per cycle while out_ready is high; every stage takes a new word
// whenever its own register is empty or is being emptied, so a stall loses or repeats nothing.
// The three stages are a constant-reciprocal multiply, a table and compare stage,
// and an add or subtract with the output register.
// Reset (rst_n low, synchronous) clears only the valid bits of the stages.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module calendar_date_ordinal_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month_in,
  input  logic [6:0]  in_day_in,
  input  logic [8:0]  in_ordinal_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_result,
  output logic        out_leap_year,
  output logic [8:0]  out_ordinal_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out
);

  cdoc_pkg::item_t   in_item;
  cdoc_pkg::s1_t     s1_data;
  cdoc_pkg::s2_t     s2_data;
  cdoc_pkg::result_t res_data;
  logic              s1_valid;
  logic              s1_ready;
  logic              s2_valid;
  logic              s2_ready;
  logic              conv_zero;
  logic              conv_one;
  logic              month_day_ok;

  // Gather the input word into one bundle for the pipeline.
  always_comb begin
    in_item.action  = in_action;
    in_item.year    = in_year;
    in_item.month   = in_month_in;
    in_item.day     = in_day_in;
    in_item.ordinal = in_ordinal_in;
  end

  // Stage one: floor(year / 25), which the leap rule needs for the
  // hundred and four-hundred tests.
  cdoc_div_stage u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_item),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // Stage two: leap flag, range checks, and either the days before the given
  // month or the month that holds the given ordinal.
  cdoc_lookup_stage u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  // Stage three: ordinal = before + day, or day = ordinal - before. Its
  // register is the output register, so the result holds while stalled.
  cdoc_result_stage u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res_data)
  );

  assign out_valid_result = res_data.valid_result;
  assign out_leap_year    = res_data.leap_year;
  assign out_ordinal_out  = res_data.ordinal_out;
  assign out_month_out    = res_data.month_out;
  assign out_day_out      = res_data.day_out;

  // Views of the output word that the checks below look at.
  assign conv_zero    = (out_ordinal_out == 9'd0) && (out_month_out == 4'd0) &&
                        (out_day_out == 5'd0);
  assign conv_one     = (out_ordinal_out != 9'd0) != (out_month_out != 4'd0);
  assign month_day_ok = (out_month_out <= cdoc_pkg::MONTH_DEC) && (out_day_out != 5'd0);

  // A rejected word must carry all-zero conversion fields.
  `ASSERT_IMPLY(a_invalid_zero, out_valid && !out_valid_result, conv_zero, "fields not zeroed")
  // A good word carries exactly one of the two conversions.
  `ASSERT_IMPLY(a_one_result, out_valid && out_valid_result, conv_one, "bad conversion fields")
  // A month from an ordinal always comes with a day in 1..31.
  `ASSERT_IMPLY(a_month_day, out_valid && (out_month_out != 4'd0), month_day_ok, "bad month or day")
  // Back-pressure reaches the input only when the first stage holds a word.
  `ASSERT_ALWAYS(a_ready_full, in_ready || s1_valid, "input stalled with empty first stage")

endmodule

FILE: hw/rtl/cdoc_div_stage.sv
`timescale 1ns / 1ps

// First stage: divides the year by 25 with a constant reciprocal.
module cdoc_div_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  cdoc_pkg::item_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output cdoc_pkg::s1_t   dn_data
);

  logic          valid_r;
  cdoc_pkg::s1_t data_r;
  cdoc_pkg::s1_t data_nxt;
  logic [28:0]   prod;

  assign prod = {15'd0, up_data.year} * {14'd0, cdoc_pkg::DIV25_RECIP};

  always_comb begin
    data_nxt.item  = up_data;
    data_nxt.quo25 = prod[cdoc_pkg::DIV25_SHIFT +: 10];
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: hw/rtl/cdoc_lookup_stage.sv
`timescale 1ns / 1ps

// Second stage: leap rule, range checks and month search.
module cdoc_lookup_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  cdoc_pkg::s1_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output cdoc_pkg::s2_t dn_data
);

  logic          valid_r;
  cdoc_pkg::s2_t data_r;
  cdoc_pkg::s2_t data_nxt;
  logic [13:0]   q25;
  logic          div25;
  logic          leap;
  logic [4:0]    mlen;
  logic [8:0]    last;
  logic [3:0]    msel;
  logic [8:0]    bsel;
  logic [8:0]    bcur;

  assign q25   = {4'd0, up_data.quo25} * cdoc_pkg::DIV25_CONST;
  assign div25 = (q25 == up_data.item.year);
  // Divisible by 4 but not by 100, or divisible by 400 (16 and 25).
  assign leap  = ((up_data.item.year[1:0] == 2'd0) && !div25) ||
                 ((up_data.item.year[3:0] == 4'd0) && div25);

  always_comb begin
    msel = 4'd1;
    bsel = 9'd0;
    bcur = 9'd0;
    // Thresholds rise with the month, so the last one below the ordinal wins.
    // The leap day only shifts the months after February.
    for (int i = 2; i <= 12; i++) begin
      bcur = cdoc_pkg::days_before(4'(i)) +
             {8'd0, leap && (4'(i) > cdoc_pkg::MONTH_FEB)};
      if (bcur < up_data.item.ordinal) begin
        msel = 4'(i);
        bsel = bcur;
      end
    end
  end

  always_comb begin
    mlen = cdoc_pkg::month_len(up_data.item.month) +
           {4'd0, (up_data.item.month == cdoc_pkg::MONTH_FEB) && leap};
    last = leap ? cdoc_pkg::DAYS_LEAP : cdoc_pkg::DAYS_COMMON;

    data_nxt.action  = up_data.item.action;
    data_nxt.leap    = leap;
    data_nxt.day     = up_data.item.day;
    data_nxt.ordinal = up_data.item.ordinal;

    if (up_data.item.action == cdoc_pkg::ACT_DATE_TO_ORD) begin
      data_nxt.ok    = (up_data.item.month != 4'd0) &&
                       (up_data.item.month <= cdoc_pkg::MONTH_DEC) &&
                       (up_data.item.day != 7'd0) &&
                       (up_data.item.day <= {2'd0, mlen});
      data_nxt.month = up_data.item.month;
      data_nxt.base  = cdoc_pkg::days_before(up_data.item.month) +
                       {8'd0, (up_data.item.month > cdoc_pkg::MONTH_FEB) && leap};
    end else begin
      data_nxt.ok    = (up_data.item.ordinal != 9'd0) && (up_data.item.ordinal <= last);
      data_nxt.month = msel;
      data_nxt.base  = bsel;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: hw/rtl/cdoc_result_stage.sv
`timescale 1ns / 1ps

// Third stage: final add or subtract, zeroing of unused fields, output register.
module cdoc_result_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  cdoc_pkg::s2_t     up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output cdoc_pkg::result_t dn_data
);

  logic              valid_r;
  cdoc_pkg::result_t data_r;
  cdoc_pkg::result_t data_nxt;
  logic [8:0]        diff;

  assign diff = up_data.ordinal - up_data.base;

  always_comb begin
    data_nxt.valid_result = up_data.ok;
    data_nxt.leap_year    = up_data.leap;
    data_nxt.ordinal_out  = 9'd0;
    data_nxt.month_out    = 4'd0;
    data_nxt.day_out      = 5'd0;
    if (up_data.ok) begin
      if (up_data.action == cdoc_pkg::ACT_DATE_TO_ORD) begin
        data_nxt.ordinal_out = up_data.base + {2'd0, up_data.day};
      end else begin
        data_nxt.month_out = up_data.month;
        data_nxt.day_out   = diff[4:0];
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: dv/cdoc_date_checker.sv
`timescale 1ns / 1ps

module cdoc_date_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month_in,
  input  logic [6:0]  in_day_in,
  input  logic [8:0]  in_ordinal_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_valid_result,
  input  logic        out_leap_year,
  input  logic [8:0]  out_ordinal_out,
  input  logic [3:0]  out_month_out,
  input  logic [4:0]  out_day_out,
  output int          mismatches,
  output int          outstanding
);

  cdoc_pkg::result_t expected_dates[$];
  int                words_seen;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    words_seen  = 0;
  end

  // Days in the year ahead of the first of month m.
  function automatic int unsigned days_ahead(input int unsigned m, input logic leap);
    int unsigned d;
    case (m)
      2:       d = 31;
      3:       d = 59;
      4:       d = 90;
      5:       d = 120;
      6:       d = 151;
      7:       d = 181;
      8:       d = 212;
      9:       d = 243;
      10:      d = 273;
      11:      d = 304;
      12:      d = 334;
      default: d = 0;
    endcase
    if (m > cdoc_pkg::MONTH_FEB && leap) begin
      d = d + 1;
    end
    return d;
  endfunction

  function automatic cdoc_pkg::result_t convert_date(input logic act, input logic [13:0] yr,
                                                     input logic [3:0] mon,
                                                     input logic [6:0] dy,
                                                     input logic [8:0] ord);
    cdoc_pkg::result_t r;
    logic              leap;
    int unsigned       len;
    int unsigned       last;
    int unsigned       m;
    r    = '0;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    r.leap_year = leap;
    if (act == cdoc_pkg::ACT_DATE_TO_ORD) begin
      if (mon >= 1 && mon <= cdoc_pkg::MONTH_DEC) begin
        case (mon)
          4, 6, 9, 11: len = 30;
          2:           len = leap ? 29 : 28;
          default:     len = 31;
        endcase
        if (dy >= 1 && dy <= len) begin
          r.valid_result = 1'b1;
          r.ordinal_out  = 9'(days_ahead(mon, leap) + dy);
        end
      end
    end else begin
      last = leap ? cdoc_pkg::DAYS_LEAP : cdoc_pkg::DAYS_COMMON;
      if (ord >= 1 && ord <= last) begin
        m = cdoc_pkg::MONTH_DEC;
        while (m > 1 && days_ahead(m, leap) >= ord) begin
          m = m - 1;
        end
        r.valid_result = 1'b1;
        r.month_out    = 4'(m);
        r.day_out      = 5'(ord - days_ahead(m, leap));
      end
    end
    return r;
  endfunction

  task automatic flag_field(input string fname, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      if (mismatches < 10) begin
        $display("Mismatch on result word %0d, %s: expected %0d, got %0d.",
                 words_seen, fname, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    cdoc_pkg::result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_dates.push_back(convert_date(in_action, in_year, in_month_in,
                                              in_day_in, in_ordinal_in));
      end
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          if (mismatches < 10) begin
            $display("Result word %0d arrived with no word outstanding.", words_seen);
          end
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          flag_field("valid_result", want.valid_result, out_valid_result);
          flag_field("leap_year", want.leap_year, out_leap_year);
          flag_field("ordinal_out", want.ordinal_out, out_ordinal_out);
          flag_field("month_out", want.month_out, out_month_out);
          flag_field("day_out", want.day_out, out_day_out);
        end
        words_seen++;
      end
    end
    outstanding <= expected_dates.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Cycles without any word moving on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // The receiver's long hold-off, long enough to fill all three stages.
  localparam int LONG_HOLD = 80;
  localparam int RANDOM_WORDS = 600;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [13:0] in_year;
  logic [3:0]  in_month_in;
  logic [6:0]  in_day_in;
  logic [8:0]  in_ordinal_in;
  logic        out_valid;
  logic        out_ready;
  logic        out_valid_result;
  logic        out_leap_year;
  logic [8:0]  out_ordinal_out;
  logic [3:0]  out_month_out;
  logic [4:0]  out_day_out;

  int mismatches;
  int outstanding;
  int idle_cycles;

  // Shared between the sender and receiver processes: no_idle switches off the random
  // gaps on both sides, and hold_req asks the receiver for one long hold-off.
  bit no_idle;
  bit hold_req;

  calendar_date_ordinal_converter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_year          (in_year),
    .in_month_in      (in_month_in),
    .in_day_in        (in_day_in),
    .in_ordinal_in    (in_ordinal_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_result (out_valid_result),
    .out_leap_year    (out_leap_year),
    .out_ordinal_out  (out_ordinal_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out)
  );

  // The checker sees both channels exactly as the block does and keeps its own
  // queue of predicted results; it hands back the mismatch count and the number
  // of words still in flight.
  cdoc_date_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_year          (in_year),
    .in_month_in      (in_month_in),
    .in_day_in        (in_day_in),
    .in_ordinal_in    (in_ordinal_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_result (out_valid_result),
    .out_leap_year    (out_leap_year),
    .out_ordinal_out  (out_ordinal_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: counts cycles in which no word is accepted on either channel. A
  // healthy block never stays silent this long, even during the long hold-off.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one word and returns at the edge at which it is taken. A gap, when
  // drawn, drops valid first; with no gap valid simply stays high and only the
  // payload changes, so valid never sees two assignments in one time step.
  task automatic send_word(input logic act, input logic [13:0] yr, input logic [3:0] mon,
                           input logic [6:0] dy, input logic [8:0] ord);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_year       <= yr;
    in_month_in   <= mon;
    in_day_in     <= dy;
    in_ordinal_in <= ord;
    do @(posedge clk); while (!in_ready);
  endtask

  // The field that the chosen action ignores is filled with noise, so that the
  // block is seen to ignore it.
  task automatic date_word(input logic [13:0] yr, input logic [3:0] mon, input logic [6:0] dy);
    send_word(cdoc_pkg::ACT_DATE_TO_ORD, yr, mon, dy, 9'($urandom));
  endtask

  task automatic ordinal_word(input logic [13:0] yr, input logic [8:0] ord);
    send_word(cdoc_pkg::ACT_ORD_TO_DATE, yr, 4'($urandom), 7'($urandom), ord);
  endtask

  // Receiver: one stall drawn per word, and the long hold-off when asked for.
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin : receive
      int stall;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [13:0] yr;
    logic [3:0]  mon;
    logic [6:0]  dy;
    logic [8:0]  ord;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    idle_cycles   = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= cdoc_pkg::ACT_DATE_TO_ORD;
    in_year       <= '0;
    in_month_in   <= '0;
    in_day_in     <= '0;
    in_ordinal_in <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words. Date to ordinal first: the leap rule at year zero, at a
    // century and at a four-hundredth year, both ends of the year, months that do
    // not exist, day zero, a day far past the month's end, and the largest years.
    date_word(14'd0, 4'd2, 7'd29);
    date_word(14'd1900, 4'd2, 7'd29);
    date_word(14'd2000, 4'd2, 7'd29);
    date_word(14'd2023, 4'd2, 7'd29);
    date_word(14'd2024, 4'd12, 7'd31);
    date_word(14'd2023, 4'd12, 7'd31);
    date_word(14'd2023, 4'd1, 7'd1);
    date_word(14'd2023, 4'd0, 7'd10);
    date_word(14'd2023, 4'd13, 7'd10);
    date_word(14'd2023, 4'd15, 7'd10);
    date_word(14'd2023, 4'd5, 7'd0);
    date_word(14'd2023, 4'd7, 7'd127);
    date_word(14'd2023, 4'd4, 7'd31);
    date_word(14'd16383, 4'd1, 7'd1);
    date_word(14'd9999, 4'd3, 7'd1);
    // Ordinal to date: ordinal zero, the first day, either side of the end of
    // February, the last day of each kind of year, one past it, and the field's top.
    ordinal_word(14'd2023, 9'd0);
    ordinal_word(14'd2023, 9'd1);
    ordinal_word(14'd2023, 9'd59);
    ordinal_word(14'd2023, 9'd60);
    ordinal_word(14'd2024, 9'd60);
    ordinal_word(14'd2023, 9'd365);
    ordinal_word(14'd2023, 9'd366);
    ordinal_word(14'd2024, 9'd366);
    ordinal_word(14'd2100, 9'd366);
    ordinal_word(14'd16383, 9'd511);

    // Random words. Most are well formed so that the table walk is exercised all
    // over the year; about one in eight of the month, day and ordinal fields is drawn over
    // its full width so that every bit toggles and the invalid paths keep being hit.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 150) no_idle = 1'b1;
      if (i == 250) no_idle = 1'b0;
      if (i == 300) hold_req = 1'b1;
      if (i == 450) begin
        // Let the pipeline drain completely before carrying on.
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
      if ($urandom_range(0, 3) == 0) begin
        yr = 14'(100 * $urandom_range(0, 163));
      end else begin
        yr = 14'($urandom_range(0, 16383));
      end
      if ($urandom_range(0, 7) == 0) begin
        mon = 4'($urandom_range(0, 15));
      end else begin
        mon = 4'($urandom_range(1, 12));
      end
      if ($urandom_range(0, 7) == 0) begin
        dy = 7'($urandom_range(0, 127));
      end else if ($urandom_range(0, 2) == 0) begin
        dy = 7'($urandom_range(27, 32));
      end else begin
        dy = 7'($urandom_range(1, 31));
      end
      if ($urandom_range(0, 7) == 0) begin
        ord = 9'($urandom_range(0, 511));
      end else if ($urandom_range(0, 3) == 0) begin
        ord = 9'($urandom_range(355, 367));
      end else begin
        ord = 9'($urandom_range(1, 366));
      end
      send_word($urandom_range(0, 1) ? cdoc_pkg::ACT_ORD_TO_DATE : cdoc_pkg::ACT_DATE_TO_ORD,
                yr, mon, dy, ord);
    end
    in_valid <= 1'b0;

    // Wait for the last results, then a few cycles more in case anything extra
    // appears at the output.
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cdoc_pkg.sv
hw/rtl/cdoc_div_stage.sv
hw/rtl/cdoc_lookup_stage.sv
hw/rtl/cdoc_result_stage.sv
hw/rtl/calendar_date_ordinal_converter_core.sv
dv/cdoc_date_checker.sv
dv/testbench.sv
